[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk_i, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication: antecedent at an edge implies consequent at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/pida_pkg.sv]
// ----------------------------------------------------------------------------
// pida_pkg
// Shared types and constants of the positional insert/delete array.
// ----------------------------------------------------------------------------
package pida_pkg;

  localparam int unsigned CAPACITY  = 32;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned CNT_OUT_W = 6;
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // common width for comparing positions against the count
  localparam int unsigned CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_READ   = 2'd2,
    ACT_REMOVE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    action_e                   action;
    logic [POS_W-1:0]          position;
    logic signed [WORD_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  read_value;
    status_e                   status;
    logic [CNT_OUT_W-1:0]      count_after;
  } rsp_t;

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic             ins;   // insert commits at position 'at'
    logic             rem;   // remove commits at position 'at'
    logic [CMP_W-1:0] at;
  } cell_ctl_t;

endpackage

[design/pida_cell.sv]
// ----------------------------------------------------------------------------
// pida_cell
// One storage slot of the array; shifts up on insert, down on remove.
// ----------------------------------------------------------------------------
module pida_cell (
  input  logic                               clk_i,
  input  pida_pkg::cell_ctl_t                ctl_i,
  input  logic [pida_pkg::CMP_W-1:0]         idx_i,
  input  logic signed [pida_pkg::WORD_W-1:0] value_i,
  input  logic signed [pida_pkg::WORD_W-1:0] lower_i,  // neighbor below
  input  logic signed [pida_pkg::WORD_W-1:0] upper_i,  // neighbor above
  output logic signed [pida_pkg::WORD_W-1:0] word_o
);

  logic signed [pida_pkg::WORD_W-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    if (ctl_i.ins) begin
      if (idx_i == ctl_i.at) begin
        word_d = value_i;
      end else if (idx_i > ctl_i.at) begin
        word_d = lower_i;
      end
    end else if (ctl_i.rem && (idx_i >= ctl_i.at)) begin
      word_d = upper_i;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

[design/positional_insert_delete_array.sv]
// ----------------------------------------------------------------------------
// positional_insert_delete_array
// Bounded ordered array of signed words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Channel | dir | handshake                 | payload
// --------+-----+---------------------------+------------------------------
// in      | in  | in_valid_i / in_stall_o   | in_data_i  (req_t)
// out     | out | out_valid_o / out_stall_i | out_data_o (rsp_t)
//
// One transfer per cycle while in_stall_o is low: every cell updates in the same
//   cycle from its neighbors, and the result is registered on acceptance.
// Reset clears the count and the output valid; cell contents are left as is
//   and never read before being written.
// in_stall_o is high only while a result waits and out_stall_i is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module positional_insert_delete_array (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pida_pkg::req_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pida_pkg::rsp_t   out_data_o
);

  logic                               in_ok;
  logic [pida_pkg::CNT_W-1:0]         count_q, count_d;
  logic                               out_valid_q;
  pida_pkg::rsp_t                     out_q, out_d;
  pida_pkg::cell_ctl_t                ctl;
  logic [pida_pkg::CMP_W-1:0]         pos_x, cnt_x, at_x;
  logic                               full, pos_lt, at_le;
  pida_pkg::status_e                  status;
  logic signed [pida_pkg::WORD_W-1:0] rd_word;
  logic signed [pida_pkg::WORD_W-1:0] cell_word [pida_pkg::CAPACITY];

  // A new request enters unless a finished result is held back downstream.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_ok      = in_valid_i && !in_stall_o;

  assign pos_x  = pida_pkg::CMP_W'(in_data_i.position);
  assign cnt_x  = pida_pkg::CMP_W'(count_q);
  assign at_x   = (in_data_i.action == pida_pkg::ACT_APPEND) ? cnt_x : pos_x;
  assign full   = (count_q == pida_pkg::CNT_W'(pida_pkg::CAPACITY));
  assign pos_lt = (pos_x < cnt_x);
  assign at_le  = (at_x <= cnt_x);

  // Decode the request into status and cell control
  always_comb begin
    status  = pida_pkg::ST_DONE;
    ctl.ins = 1'b0;
    ctl.rem = 1'b0;
    ctl.at  = at_x;
    unique case (in_data_i.action)
      pida_pkg::ACT_APPEND, pida_pkg::ACT_INSERT: begin
        if (full) begin
          status = pida_pkg::ST_FULL;
        end else if (!at_le) begin
          status = pida_pkg::ST_RANGE;
        end else begin
          ctl.ins = in_ok;
        end
      end
      pida_pkg::ACT_READ: begin
        if (!pos_lt) status = pida_pkg::ST_RANGE;
      end
      pida_pkg::ACT_REMOVE: begin
        if (!pos_lt) begin
          status = pida_pkg::ST_RANGE;
        end else begin
          ctl.rem = in_ok;
        end
      end
      default: status = pida_pkg::ST_DONE;
    endcase
  end

  // Row of cells; the word at the top edge enters nothing on insert,
  // and the cell at the top takes a don't-care word on remove.
  for (genvar i = 0; i < pida_pkg::CAPACITY; i++) begin : g_cell
    logic signed [pida_pkg::WORD_W-1:0] lower, upper;
    if (i == 0) begin : g_lo
      assign lower = '0;
    end else begin : g_lo
      assign lower = cell_word[i-1];
    end
    if (i == pida_pkg::CAPACITY - 1) begin : g_hi
      assign upper = '0;
    end else begin : g_hi
      assign upper = cell_word[i+1];
    end
    pida_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .idx_i   (pida_pkg::CMP_W'(i)),
      .value_i (in_data_i.value),
      .lower_i (lower),
      .upper_i (upper),
      .word_o  (cell_word[i])
    );
  end

  // Read port: only used when position is below the count, so in range.
  assign rd_word = cell_word[pos_x[pida_pkg::IDX_W-1:0]];

  always_comb begin
    count_d = count_q;
    if (ctl.ins) begin
      count_d = count_q + pida_pkg::CNT_W'(1);
    end else if (ctl.rem) begin
      count_d = count_q - pida_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    out_d.status      = status;
    out_d.count_after = pida_pkg::CNT_OUT_W'(count_d);
    out_d.read_value  = ((in_data_i.action == pida_pkg::ACT_READ) && pos_lt) ? rd_word : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ok) count_q <= count_d;
      if (in_ok) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ok) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_CLK(a_count_bound, count_q <= pida_pkg::CNT_W'(pida_pkg::CAPACITY), "count above capacity")
  `ASSERT_NEXT(a_ins_grows, ctl.ins, count_q == $past(count_q) + pida_pkg::CNT_W'(1), "insert did not grow count")
  `ASSERT_NEXT(a_rem_shrinks, ctl.rem, count_q == $past(count_q) - pida_pkg::CNT_W'(1), "remove did not shrink count")
  `ASSERT_CLK(a_full_holds, !(out_valid_q && out_q.status == pida_pkg::ST_FULL) || full, "full status with free room")

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for positional_insert_delete_array. A scoreboard keeps
// its own copy of the ordered store and its length, predicts the response of
// every accepted request, and compares each response field by field. The
// stimulus is a short directed sequence followed by random bursts that grow,
// shrink and scramble the store, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pida_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 830;
  localparam int unsigned IDLE_LIMIT   = 2000;  // cycles without any transfer
  localparam int unsigned DRAIN_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;     // result is registered on accept
  localparam int unsigned HOLD_AFTER   = 300;   // responses seen before the long hold-off
  localparam int unsigned HOLD_CYCLES  = 160;
  localparam int unsigned POS_MAX      = (1 << POS_W) - 1;

  // Request mixes for the random bursts
  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_BALANCED,
    MIX_NOISE
  } mix_e;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow store plus the queue of responses still to arrive
  // --------------------------------------------------------------------------
  class array_scoreboard;
    logic signed [WORD_W-1:0] held_words [CAPACITY];
    int unsigned              held_count;
    rsp_t                     awaited_rsp [$];
    int unsigned              errors;
    int unsigned              checked;

    function new();
      held_count = 0;
      errors     = 0;
      checked    = 0;
    endfunction

    // Apply one accepted request to the shadow store and queue its response
    function void note_request(req_t req);
      rsp_t        rsp;
      int unsigned at;
      int unsigned idx;
      rsp        = '0;
      rsp.status = ST_DONE;
      case (req.action)
        ACT_APPEND, ACT_INSERT: begin
          at = (req.action == ACT_APPEND) ? held_count : int'(req.position);
          // full is checked before the position
          if (held_count >= CAPACITY) begin
            rsp.status = ST_FULL;
          end else if (at > held_count) begin
            rsp.status = ST_RANGE;
          end else begin
            for (idx = held_count; idx > at; idx--) held_words[idx] = held_words[idx-1];
            held_words[at] = req.value;
            held_count++;
          end
        end
        ACT_READ: begin
          if (req.position >= held_count) rsp.status = ST_RANGE;
          else rsp.read_value = held_words[req.position];
        end
        default: begin
          if (req.position >= held_count) begin
            rsp.status = ST_RANGE;
          end else begin
            for (idx = req.position; idx + 1 < held_count; idx++)
              held_words[idx] = held_words[idx+1];
            held_count--;
          end
        end
      endcase
      rsp.count_after = CNT_OUT_W'(held_count);
      awaited_rsp.push_back(rsp);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      checked++;
      if (awaited_rsp.size() == 0) begin
        $display("%0t: response with no request outstanding: value %0d status %0d count %0d",
                 $time, got.read_value, got.status, got.count_after);
        errors++;
        return;
      end
      want = awaited_rsp.pop_front();
      if (got.read_value !== want.read_value) begin
        $display("%0t: read_value expected %0d actual %0d",
                 $time, want.read_value, got.read_value);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.count_after !== want.count_after) begin
        $display("%0t: count_after expected %0d actual %0d",
                 $time, want.count_after, got.count_after);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return awaited_rsp.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  req_t in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;

  array_scoreboard sb = new();

  positional_insert_delete_array dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Monitor: a transfer happens at a rising edge with valid high, stall low.
  // The response side is handled first; it can never belong to the request
  // taken at the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_response(out_data);
      if (in_valid && !in_stall) sb.note_request(in_data);
    end
  end

  // Watchdog: ends the run if no transfer happens on either side for too long
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
    $display("positional_insert_delete_array test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: stretches of free flow, sparse and dense random stalls, and a
  // fixed pattern. Once, after enough responses, it holds off long enough
  // for the block to back up and stall its input.
  // --------------------------------------------------------------------------
  initial begin : receiver
    bit          held_off;
    int unsigned mode;
    int unsigned span;
    int unsigned k;
    held_off = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held_off && sb.checked >= HOLD_AFTER) begin
        held_off = 1'b1;
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(1, 40);
        for (k = 0; k < span; k++) begin
          @(negedge clk);
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= $urandom_range(0, 1);
            default: out_stall <= (k % 3 != 0);
          endcase
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers. Called at a falling edge; return after the transfer.
  // --------------------------------------------------------------------------
  task automatic drive_request(req_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_fixed(action_e act, int unsigned pos, logic signed [WORD_W-1:0] val);
    req_t req;
    req.action   = act;
    req.position = POS_W'(pos);
    req.value    = val;
    @(negedge clk);
    drive_request(req);
  endtask

  // Random request, positions chosen against the shadow count so most hit
  function automatic req_t pick_request(mix_e mix);
    req_t        req;
    int unsigned roll;
    int unsigned cnt;
    cnt  = sb.held_count;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (roll < 45)      req.action = ACT_APPEND;
        else if (roll < 85) req.action = ACT_INSERT;
        else if (roll < 95) req.action = ACT_READ;
        else                req.action = ACT_REMOVE;
      end
      MIX_SHRINK: begin
        if (roll < 55)      req.action = ACT_REMOVE;
        else if (roll < 80) req.action = ACT_READ;
        else if (roll < 90) req.action = ACT_APPEND;
        else                req.action = ACT_INSERT;
      end
      default: req.action = action_e'($urandom_range(0, 3));
    endcase

    roll = $urandom_range(0, 99);
    if (mix == MIX_NOISE || roll < 12)       req.position = POS_W'($urandom_range(0, POS_MAX));
    else if (roll < 22)                      req.position = POS_W'(cnt);  // edge of range
    else if (req.action == ACT_INSERT)       req.position = POS_W'($urandom_range(0, cnt));
    else if (cnt == 0)                       req.position = '0;
    else                                     req.position = POS_W'($urandom_range(0, cnt - 1));

    case ($urandom_range(0, 7))
      0:       req.value = {1'b1, {(WORD_W-1){1'b0}}};
      1:       req.value = {1'b0, {(WORD_W-1){1'b1}}};
      2:       req.value = '0;
      3:       req.value = '1;
      default: req.value = $urandom;
    endcase
    return req;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    int unsigned waited;
    bit          paused;
    mix_e        mix;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty store, bad positions, value extremes, inserts at the
    // front, middle and end, reads and removes at both ends and past them.
    send_fixed(ACT_READ,   0,       32'sd0);            // read of empty store
    send_fixed(ACT_REMOVE, 0,       32'sd0);            // remove from empty store
    send_fixed(ACT_INSERT, 1,       32'sd5);            // insert past count
    send_fixed(ACT_INSERT, POS_MAX, 32'sd5);            // largest position
    send_fixed(ACT_APPEND, 0,       32'sh7FFF_FFFF);
    send_fixed(ACT_APPEND, POS_MAX, 32'sh8000_0000);    // position ignored
    send_fixed(ACT_INSERT, 0,       32'sd0);            // insert at front
    send_fixed(ACT_INSERT, 3,       -32'sd1);           // position == count appends
    send_fixed(ACT_INSERT, 1,       32'sh5555_5555);    // insert in the middle
    send_fixed(ACT_READ,   0,       -32'sd1);           // value ignored
    send_fixed(ACT_READ,   4,       32'sd0);            // last entry
    send_fixed(ACT_READ,   5,       32'sd0);            // position == count
    send_fixed(ACT_READ,   POS_MAX, 32'sd0);
    send_fixed(ACT_READ,   1,       32'sd0);
    send_fixed(ACT_REMOVE, POS_MAX, 32'sd0);
    send_fixed(ACT_REMOVE, 5,       32'sd0);            // position == count
    send_fixed(ACT_REMOVE, 2,       32'sd0);            // middle, upper entries move down
    send_fixed(ACT_REMOVE, 3,       32'sd0);            // last entry
    send_fixed(ACT_REMOVE, 0,       32'sd0);            // first entry
    send_fixed(ACT_APPEND, 0,       32'shAAAA_AAAA);
    send_fixed(ACT_READ,   0,       32'sd0);
    send_fixed(ACT_READ,   2,       32'sd0);

    // Random bursts with gaps; once, halfway, wait for the block to drain
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      mix   = mix_e'($urandom_range(0, 3));
      burst = $urandom_range(1, 32);
      repeat (burst) begin
        @(negedge clk);
        drive_request(pick_request(mix));
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
      end else if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain, then a few more cycles to catch stray responses
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      $display("%0t: %0d responses never arrived", $time, sb.pending());

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("positional_insert_delete_array test passed");
    end else begin
      $display("positional_insert_delete_array test failed");
    end
    $finish;
  end

endmodule
